// ===== rtl/keypad_matrix_event_scanner_defines.svh =====
// Assertion macros used by the checker file.
`ifndef KEYPAD_MATRIX_EVENT_SCANNER_DEFINES_SVH
`define KEYPAD_MATRIX_EVENT_SCANNER_DEFINES_SVH

// Property checked on every clock edge outside reset.
`define KMES_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Property checked on every clock edge, reset included.
`define KMES_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== rtl/kmes_pkg.sv =====
`timescale 1ns / 1ps
package kmes_pkg;

   localparam int MATRIX_ROWS = 5;
   localparam int MATRIX_COLS = 6;
   localparam int NKEYS       = MATRIX_ROWS * MATRIX_COLS;
   localparam int KEY_IDX_W   = $clog2(NKEYS);
   localparam int KEY_CNT_W   = $clog2(NKEYS + 1);

   localparam logic [5:0] POS_BUTTON    = 6'(NKEYS);
   localparam logic [5:0] POS_ENC_LEFT  = 6'(NKEYS + 1);
   localparam logic [5:0] POS_ENC_RIGHT = 6'(NKEYS + 2);

   localparam logic [1:0] ACT_DOWN = 2'd0;
   localparam logic [1:0] ACT_UP   = 2'd1;
   localparam logic [1:0] ACT_LONG = 2'd2;

   localparam int CSR_ADDR_W = 4;
   localparam logic [1:0] REG_LONG_PRESS  = 2'd0;
   localparam logic [1:0] REG_KEY_RELEASE = 2'd1;
   localparam logic [1:0] REG_BTN_RELEASE = 2'd2;
   localparam logic [1:0] REG_KEY_MASK    = 2'd3;

   localparam logic [15:0] LONG_PRESS_RESET  = 16'd500;
   localparam logic [15:0] KEY_RELEASE_RESET = 16'd100;
   localparam logic [15:0] BTN_RELEASE_RESET = 16'd50;
   localparam logic [29:0] KEY_MASK_RESET    = 30'd15986687;

   typedef enum logic [1:0] {
      PH_IDLE   = 2'd0,
      PH_TIMING = 2'd1,
      PH_WAIT   = 2'd2
   } phase_type;

   typedef struct packed {
      phase_type   phase;
      logic [31:0] press_time;
   } key_word_type;

   localparam int KEY_WORD_W = $bits(key_word_type);

   typedef struct packed {
      logic [31:0] now_ms;
      logic [29:0] key_levels;
      logic        button_level;
      logic        enc_left_level;
      logic        enc_right_level;
   } req_type;

   typedef struct packed {
      logic [5:0] key_position;
      logic [1:0] action;
      logic       last_event;
   } rsp_type;

endpackage

// ===== rtl/kmes_ram.sv =====
`timescale 1ns / 1ps
module kmes_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/keypad_matrix_event_scanner.sv =====
`timescale 1ns / 1ps
// Keypad matrix event scanner. Each accepted scan (time stamp, matrix levels, push button,
// encoder lines) yields zero or more events in order: fitted matrix keys by index
// column*rows+row, then the button, then the encoder; last_event marks the final event of
// a scan. Per-key phase and press time live in a one-port-read, one-port-write RAM that is
// walked once per scan with read and write-back overlapped; the walk can be held while the
// result side stalls. The next scan is taken as soon as the walk ends, while the final
// event may still wait in the output register. Key phases reset through per-entry valid
// flops, so no clearing pass is needed. Registers sit at byte addresses 0, 4, 8 and 12 of
// the APB-style port.
module keypad_matrix_event_scanner
   import kmes_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_KEYS,
      S_BUTTON,
      S_ENC,
      S_FLUSH
   } state_type;

   // configuration
   logic [15:0] long_ms_ff, key_rel_ff, btn_rel_ff;
   logic [29:0] key_mask_ff;
   logic        csr_wr;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         long_ms_ff  <= LONG_PRESS_RESET;
         key_rel_ff  <= KEY_RELEASE_RESET;
         btn_rel_ff  <= BTN_RELEASE_RESET;
         key_mask_ff <= KEY_MASK_RESET;
      end else if (csr_wr) begin
         unique case (paddr[3:2])
            REG_LONG_PRESS:  long_ms_ff  <= pwdata[15:0];
            REG_KEY_RELEASE: key_rel_ff  <= pwdata[15:0];
            REG_BTN_RELEASE: btn_rel_ff  <= pwdata[15:0];
            REG_KEY_MASK:    key_mask_ff <= pwdata[29:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         REG_LONG_PRESS:  prdata = {16'd0, long_ms_ff};
         REG_KEY_RELEASE: prdata = {16'd0, key_rel_ff};
         REG_BTN_RELEASE: prdata = {16'd0, btn_rel_ff};
         REG_KEY_MASK:    prdata = {2'd0, key_mask_ff};
         default:         prdata = 32'd0;
      endcase
   end

   // sequencer state
   state_type            state_ff, state_in;
   req_type              scan_ff, scan_in;
   logic [KEY_CNT_W-1:0] rd_idx_ff, rd_idx_in;
   logic                 p_vld_ff, p_vld_in;
   logic [KEY_IDX_W-1:0] p_idx_ff, p_idx_in;
   logic [NKEYS-1:0]     key_vld_ff, key_vld_in;
   logic                 pend_vld_ff, pend_vld_in;
   rsp_type              pend_ff, pend_in;
   logic                 out_vld_ff, out_vld_in;
   rsp_type              out_ff, out_in;
   logic                 btn_timing_ff, btn_timing_in;
   logic [31:0]          btn_time_ff, btn_time_in;
   logic                 btn_armed_ff, btn_armed_in;
   logic                 enc_armed_ff, enc_armed_in;

   // key RAM
   logic                  ram_we, ram_re;
   logic [KEY_WORD_W-1:0] ram_rdata;
   key_word_type          rd_word, wr_word;

   kmes_ram #(
      .WIDTH (KEY_WORD_W),
      .DEPTH (NKEYS)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (p_idx_ff),
      .wr_data (wr_word),
      .rd_en   (ram_re),
      .rd_addr (rd_idx_ff[KEY_IDX_W-1:0]),
      .rd_data (ram_rdata)
   );

   assign rd_word = key_word_type'(ram_rdata);

   logic        out_free, can_emit;
   logic [31:0] dt;
   phase_type   key_ph;
   logic        key_pressed, key_present;
   logic        key_ev, key_we, key_go;
   logic [1:0]  key_act;
   logic        btn_press, btn_armed_eff;
   logic        emit_req;
   rsp_type     emit_rsp;

   assign out_free = !out_vld_ff || !rsp_stall;
   assign can_emit = !pend_vld_ff || out_free;
   assign dt = scan_ff.now_ms - ((state_ff == S_BUTTON) ? btn_time_ff : rd_word.press_time);

   // per-key decision on the entry held in the RAM read register
   always_comb begin
      key_ph      = key_vld_ff[p_idx_ff] ? rd_word.phase : PH_IDLE;
      key_pressed = !scan_ff.key_levels[p_idx_ff];
      key_present = key_mask_ff[p_idx_ff];
      key_ev      = 1'b0;
      key_we      = 1'b0;
      key_act     = ACT_DOWN;
      wr_word     = rd_word;
      case (key_ph)
         PH_TIMING: begin
            if (dt > 32'(long_ms_ff)) begin
               key_ev        = 1'b1;
               key_we        = 1'b1;
               key_act       = ACT_LONG;
               wr_word.phase = PH_WAIT;
            end else if (dt > 32'(key_rel_ff) && !key_pressed) begin
               key_ev        = 1'b1;
               key_we        = 1'b1;
               key_act       = ACT_UP;
               wr_word.phase = PH_WAIT;
            end
         end
         PH_IDLE: begin
            if (key_pressed) begin
               key_ev             = 1'b1;
               key_we             = 1'b1;
               wr_word.phase      = PH_TIMING;
               wr_word.press_time = scan_ff.now_ms;
            end
         end
         default: begin
            if (!key_pressed) begin
               key_we        = 1'b1;
               wr_word.phase = PH_IDLE;
            end
         end
      endcase
      if (!key_present || !p_vld_ff) begin
         key_ev = 1'b0;
         key_we = 1'b0;
      end
   end

   assign key_go        = !key_ev || can_emit;
   assign btn_press     = !scan_ff.button_level;
   assign btn_armed_eff = btn_armed_ff || !btn_press;

   always_comb begin
      state_in      = state_ff;
      scan_in       = scan_ff;
      rd_idx_in     = rd_idx_ff;
      p_vld_in      = p_vld_ff;
      p_idx_in      = p_idx_ff;
      key_vld_in    = key_vld_ff;
      pend_vld_in   = pend_vld_ff;
      pend_in       = pend_ff;
      out_in        = out_ff;
      btn_timing_in = btn_timing_ff;
      btn_time_in   = btn_time_ff;
      btn_armed_in  = btn_armed_ff;
      enc_armed_in  = enc_armed_ff;
      ram_we        = 1'b0;
      ram_re        = 1'b0;
      emit_req      = 1'b0;
      emit_rsp      = '{key_position: 6'(p_idx_ff), action: key_act, last_event: 1'b0};

      // drop a result once transferred
      out_vld_in = out_vld_ff && rsp_stall;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               scan_in   = req_data;
               rd_idx_in = '0;
               p_vld_in  = 1'b0;
               state_in  = S_KEYS;
            end
         end
         S_KEYS: begin
            if (key_go) begin
               ram_we   = key_we;
               emit_req = key_ev;
               if (key_we) begin
                  key_vld_in[p_idx_ff] = 1'b1;
               end
               if (rd_idx_ff < KEY_CNT_W'(NKEYS)) begin
                  ram_re    = 1'b1;
                  p_vld_in  = 1'b1;
                  p_idx_in  = rd_idx_ff[KEY_IDX_W-1:0];
                  rd_idx_in = rd_idx_ff + KEY_CNT_W'(1);
               end else begin
                  p_vld_in = 1'b0;
                  state_in = S_BUTTON;
               end
            end
         end
         S_BUTTON: begin
            emit_rsp.key_position = POS_BUTTON;
            btn_armed_in = btn_armed_eff;
            if (btn_armed_eff) begin
               if (btn_timing_ff) begin
                  if (btn_press && dt > 32'(long_ms_ff)) begin
                     emit_req        = 1'b1;
                     emit_rsp.action = ACT_LONG;
                     btn_timing_in   = 1'b0;
                     btn_armed_in    = 1'b0;
                  end else if (!btn_press && dt > 32'(btn_rel_ff)) begin
                     emit_req        = 1'b1;
                     emit_rsp.action = ACT_UP;
                     btn_timing_in   = 1'b0;
                  end
               end else if (btn_press) begin
                  emit_req        = 1'b1;
                  emit_rsp.action = ACT_DOWN;
                  btn_timing_in   = 1'b1;
                  btn_time_in     = scan_ff.now_ms;
               end
            end
            if (emit_req && !can_emit) begin
               // hold until the pending event can move on
               emit_req      = 1'b0;
               btn_timing_in = btn_timing_ff;
               btn_time_in   = btn_time_ff;
               btn_armed_in  = btn_armed_ff;
            end else begin
               state_in = S_ENC;
            end
         end
         S_ENC: begin
            emit_rsp.action = ACT_DOWN;
            if (scan_ff.enc_left_level && scan_ff.enc_right_level) begin
               enc_armed_in = 1'b1;
            end else if (enc_armed_ff && scan_ff.enc_left_level) begin
               emit_req              = 1'b1;
               emit_rsp.key_position = POS_ENC_LEFT;
               enc_armed_in          = 1'b0;
            end else if (enc_armed_ff && scan_ff.enc_right_level) begin
               emit_req              = 1'b1;
               emit_rsp.key_position = POS_ENC_RIGHT;
               enc_armed_in          = 1'b0;
            end
            if (emit_req && !can_emit) begin
               emit_req     = 1'b0;
               enc_armed_in = enc_armed_ff;
            end else begin
               state_in = S_FLUSH;
            end
         end
         S_FLUSH: begin
            if (!pend_vld_ff) begin
               state_in = S_IDLE;
            end else if (out_free) begin
               out_in            = pend_ff;
               out_in.last_event = 1'b1;
               out_vld_in        = 1'b1;
               pend_vld_in       = 1'b0;
               state_in          = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      // a new event pushes the held one out; last_event is only known at the flush
      if (emit_req) begin
         if (pend_vld_ff) begin
            out_in     = pend_ff;
            out_vld_in = 1'b1;
         end
         pend_in     = emit_rsp;
         pend_vld_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rd_idx_ff     <= '0;
         p_vld_ff      <= 1'b0;
         key_vld_ff    <= '0;
         pend_vld_ff   <= 1'b0;
         out_vld_ff    <= 1'b0;
         btn_timing_ff <= 1'b0;
         btn_time_ff   <= 32'd0;
         btn_armed_ff  <= 1'b1;
         enc_armed_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rd_idx_ff     <= rd_idx_in;
         p_vld_ff      <= p_vld_in;
         key_vld_ff    <= key_vld_in;
         pend_vld_ff   <= pend_vld_in;
         out_vld_ff    <= out_vld_in;
         btn_timing_ff <= btn_timing_in;
         btn_time_ff   <= btn_time_in;
         btn_armed_ff  <= btn_armed_in;
         enc_armed_ff  <= enc_armed_in;
      end
      scan_ff  <= scan_in;
      p_idx_ff <= p_idx_in;
      pend_ff  <= pend_in;
      out_ff   <= out_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_ff;

endmodule

// ===== rtl/kmes_checker.sv =====
`timescale 1ns / 1ps
`include "keypad_matrix_event_scanner_defines.svh"
module kmes_assertions
   import kmes_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // a stalled result holds
   property p_rsp_hold;
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data);
   endproperty

   // a scan keeps the input side closed for its walk
   property p_scan_busy;
      req_valid && !req_stall |=> req_stall;
   endproperty

   // only defined positions and actions leave the block
   property p_rsp_codes;
      rsp_valid |-> rsp_data.action <= ACT_LONG && rsp_data.key_position <= POS_ENC_RIGHT;
   endproperty

   // no result right after reset
   property p_reset_empty;
      reset |=> !rsp_valid;
   endproperty

   `KMES_ASSERT(a_rsp_hold, p_rsp_hold, "result changed while stalled")
   `KMES_ASSERT(a_scan_busy, p_scan_busy, "scan accepted back to back")
   `KMES_ASSERT(a_rsp_codes, p_rsp_codes, "bad result code")
   `KMES_ASSERT_ALWAYS(a_reset_empty, p_reset_empty, "result valid after reset")

endmodule

bind keypad_matrix_event_scanner kmes_assertions u_kmes_checker (.*);
